FILE: rtl/core/msp_pkg.sv
`default_nettype none

package msp_pkg;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_HEADER   = 2'd1,
        PH_PAYLOAD  = 2'd2,
        PH_CHECKSUM = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_MAX_PAYLOAD_SIZE   = 2'd0,
        REG_CHECK_NON_PROTOCOL = 2'd1,
        REG_REBOOT_CHAR        = 2'd2,
        REG_UNUSED             = 2'd3
    } reg_index_t;

    localparam logic [7:0] START_BYTE             = 8'h24;
    localparam logic [7:0] MAX_PAYLOAD_SIZE_RESET = 8'd192;
    localparam logic       CHECK_NON_PROTO_RESET  = 1'b0;
    localparam logic [7:0] REBOOT_CHAR_RESET      = 8'd82;

    typedef struct packed {
        logic       consumed;
        logic       payload_valid;
        logic [7:0] payload_index;
        logic [7:0] payload_data;
        logic       frame_end;
        logic       checksum_ok;
        logic [7:0] frame_command;
        logic [7:0] frame_size;
        logic       size_rejected;
        logic       reboot_request;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/msp_frame_receive_parser.sv
// An accepted rx_byte's result is registered and appears on the outputs in the cycle after it is taken.
// Throughput: one byte per cycle while the output is not stalled; the parser state updates when a byte is taken.
// in_ready stays high while the output register is empty or being drained.
// Reset (rst_n low, asynchronous): parser idle, state cleared, output empty,
// config registers at max_payload_size 192, check_non_protocol 0, reboot_char 82.
`default_nettype none

module msp_frame_receive_parser (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            consumed,
    output logic            payload_valid,
    output logic [7:0]      payload_index,
    output logic [7:0]      payload_data,
    output logic            frame_end,
    output logic            checksum_ok,
    output logic [7:0]      frame_command,
    output logic [7:0]      frame_size,
    output logic            size_rejected,
    output logic            reboot_request,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    logic [7:0] max_payload_size_reg;
    logic       check_non_protocol_reg;
    logic [7:0] reboot_char_reg;

    msp_pkg::phase_t phase_reg, phase_next;
    logic            header_count_reg, header_count_next;
    logic [7:0]      byte_offset_reg, byte_offset_next;
    logic [7:0]      running_xor_reg, running_xor_next;
    logic [7:0]      size_held_reg, size_held_next;
    logic [7:0]      command_held_reg, command_held_next;

    msp_pkg::result_t result_reg, result_next;
    logic             out_valid_reg;
    logic             in_take;
    logic [7:0]       offset_inc;

    assign cfg_ready  = 1'b1;
    assign in_ready   = !out_valid_reg || out_ready;
    assign in_take    = in_valid && in_ready;
    assign offset_inc = byte_offset_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_size_reg   <= msp_pkg::MAX_PAYLOAD_SIZE_RESET;
            check_non_protocol_reg <= msp_pkg::CHECK_NON_PROTO_RESET;
            reboot_char_reg        <= msp_pkg::REBOOT_CHAR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (msp_pkg::reg_index_t'(cfg_index))
                msp_pkg::REG_MAX_PAYLOAD_SIZE:   max_payload_size_reg   <= cfg_data;
                msp_pkg::REG_CHECK_NON_PROTOCOL: check_non_protocol_reg <= cfg_data[0];
                msp_pkg::REG_REBOOT_CHAR:        reboot_char_reg        <= cfg_data;
                default:                         ;
            endcase
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            msp_pkg::PH_IDLE:
            begin
                if (rx_byte == msp_pkg::START_BYTE)
                    phase_next = msp_pkg::PH_HEADER;
            end
            msp_pkg::PH_HEADER:
            begin
                if (header_count_reg)
                begin
                    if (size_held_reg > max_payload_size_reg)
                        phase_next = msp_pkg::PH_IDLE;
                    else if (size_held_reg != 8'd0)
                        phase_next = msp_pkg::PH_PAYLOAD;
                    else
                        phase_next = msp_pkg::PH_CHECKSUM;
                end
            end
            msp_pkg::PH_PAYLOAD:
            begin
                if (offset_inc == size_held_reg)
                    phase_next = msp_pkg::PH_CHECKSUM;
            end
            msp_pkg::PH_CHECKSUM: phase_next = msp_pkg::PH_IDLE;
            default:              phase_next = msp_pkg::PH_IDLE;
        endcase
    end

    // state datapath and result
    always_comb
    begin
        header_count_next = header_count_reg;
        byte_offset_next  = byte_offset_reg;
        running_xor_next  = running_xor_reg;
        size_held_next    = size_held_reg;
        command_held_next = command_held_reg;
        result_next       = '0;
        result_next.consumed = 1'b1;
        unique case (phase_reg)
            msp_pkg::PH_IDLE:
            begin
                if (rx_byte == msp_pkg::START_BYTE)
                begin
                    header_count_next = 1'b0;
                    byte_offset_next  = 8'd0;
                    running_xor_next  = 8'd0;
                    size_held_next    = 8'd0;
                    command_held_next = 8'd0;
                end
                else
                begin
                    result_next.consumed       = 1'b0;
                    result_next.reboot_request = check_non_protocol_reg
                                                 && (rx_byte == reboot_char_reg);
                end
            end
            msp_pkg::PH_HEADER:
            begin
                running_xor_next = running_xor_reg ^ rx_byte;
                if (!header_count_reg)
                begin
                    size_held_next    = rx_byte;
                    header_count_next = 1'b1;
                end
                else
                begin
                    command_held_next = rx_byte;
                    header_count_next = 1'b0;
                    byte_offset_next  = 8'd0;
                    result_next.size_rejected = size_held_reg > max_payload_size_reg;
                end
            end
            msp_pkg::PH_PAYLOAD:
            begin
                result_next.payload_valid = 1'b1;
                result_next.payload_index = byte_offset_reg;
                result_next.payload_data  = rx_byte;
                running_xor_next          = running_xor_reg ^ rx_byte;
                byte_offset_next          = offset_inc;
            end
            msp_pkg::PH_CHECKSUM:
            begin
                result_next.frame_end   = 1'b1;
                result_next.checksum_ok = running_xor_reg == rx_byte;
            end
            default: ;
        endcase
        if (result_next.consumed)
        begin
            result_next.frame_command = command_held_next;
            result_next.frame_size    = size_held_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= msp_pkg::PH_IDLE;
            header_count_reg <= 1'b0;
            byte_offset_reg  <= 8'd0;
            running_xor_reg  <= 8'd0;
            size_held_reg    <= 8'd0;
            command_held_reg <= 8'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                phase_reg        <= phase_next;
                header_count_reg <= header_count_next;
                byte_offset_reg  <= byte_offset_next;
                running_xor_reg  <= running_xor_next;
                size_held_reg    <= size_held_next;
                command_held_reg <= command_held_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign consumed       = result_reg.consumed;
    assign payload_valid  = result_reg.payload_valid;
    assign payload_index  = result_reg.payload_index;
    assign payload_data   = result_reg.payload_data;
    assign frame_end      = result_reg.frame_end;
    assign checksum_ok    = result_reg.checksum_ok;
    assign frame_command  = result_reg.frame_command;
    assign frame_size     = result_reg.frame_size;
    assign size_rejected  = result_reg.size_rejected;
    assign reboot_request = result_reg.reboot_request;

endmodule

`default_nettype wire

FILE: rtl/core/msp_chk.sv
`default_nettype none

module msp_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       consumed,
    input wire logic       payload_valid,
    input wire logic [7:0] payload_index,
    input wire logic [7:0] payload_data,
    input wire logic       frame_end,
    input wire logic       checksum_ok,
    input wire logic [7:0] frame_command,
    input wire logic [7:0] frame_size,
    input wire logic       size_rejected,
    input wire logic       reboot_request
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload_data)
            && $stable(frame_end) && $stable(consumed) && $stable(payload_index))
        else $error("stalled result item changed");

    a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (payload_valid || frame_end || size_rejected)
            |-> consumed && !reboot_request
                && !(payload_valid && frame_end) && !(size_rejected && frame_end))
        else $error("result item flags conflict");

    a_non_proto: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !consumed |-> frame_command == 8'd0 && frame_size == 8'd0)
        else $error("non-protocol item carries frame header");

    a_cksum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && checksum_ok |-> frame_end)
        else $error("checksum_ok without frame end");

    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |-> payload_index < frame_size)
        else $error("payload index past frame size");

endmodule

bind msp_frame_receive_parser msp_chk u_msp_chk (.*);

`default_nettype wire
